@@ rtl/poi_pkg.sv @@
package poi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int TAB_LEN          = 24;
    localparam int TAB_IDX_W        = 5;
    localparam int CORDIC_W         = 44;
    localparam int ZW               = 34;
    localparam int MUL_A_W          = 32;
    localparam int MUL_B_W          = 31;
    localparam int PROD_W           = MUL_A_W + MUL_B_W;

    localparam logic [29:0] INVK_Q30       = 30'd652032874;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MV,
        S_MU,
        S_PRE,
        S_RINIT,
        S_RSTEP,
        S_XLO,
        S_XHI,
        S_XSUM,
        S_XACC,
        S_YLO,
        S_YHI,
        S_YSUM,
        S_YACC,
        S_W,
        S_R,
        S_H,
        S_HD,
        S_QINIT,
        S_QSTEP,
        S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_VK,
        OP_MUL_UK,
        OP_SET_RY,
        OP_ROT_INIT,
        OP_CSTEP,
        OP_MUL_XLO,
        OP_MUL_XHI,
        OP_MUL_YLO,
        OP_MUL_YHI,
        OP_SUM,
        OP_ACC_X,
        OP_ACC_Y,
        OP_MUL_WDT,
        OP_SET_R16,
        OP_MUL_RINV,
        OP_HEAD,
        OP_QUAT_INIT,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [TAB_IDX_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } status_t;

    function automatic logic [29:0] atan_val(input logic [TAB_IDX_W-1:0] idx);
        logic [29:0] r;
        unique case (idx)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10680862;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            5'd20:   r = 30'd652;
            5'd21:   r = 30'd326;
            5'd22:   r = 30'd163;
            5'd23:   r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/poi_ctrl.sv @@
module poi_ctrl
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int NSTEP = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam int SW    = $clog2(NSTEP);

    state_t         state_reg;
    state_t         state_next;
    logic [SW-1:0]  step_reg;
    logic [SW-1:0]  step_next;
    logic           last_step;

    assign last_step = (step_reg == SW'(NSTEP - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_stall   = 1'b1;
        cmd.op     = OP_NOP;
        cmd.step   = TAB_IDX_W'(step_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MV;
                end
            end
            S_MV:
            begin
                cmd.op     = OP_MUL_VK;
                state_next = S_MU;
            end
            S_MU:
            begin
                cmd.op     = OP_MUL_UK;
                state_next = S_PRE;
            end
            S_PRE:
            begin
                cmd.op     = OP_SET_RY;
                state_next = S_RINIT;
            end
            S_RINIT:
            begin
                cmd.op     = OP_ROT_INIT;
                step_next  = '0;
                state_next = S_RSTEP;
            end
            S_RSTEP:
            begin
                cmd.op = OP_CSTEP;
                if (last_step)
                begin
                    state_next = S_XLO;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_XLO:
            begin
                cmd.op     = OP_MUL_XLO;
                state_next = S_XHI;
            end
            S_XHI:
            begin
                cmd.op     = OP_MUL_XHI;
                state_next = S_XSUM;
            end
            S_XSUM:
            begin
                cmd.op     = OP_SUM;
                state_next = S_XACC;
            end
            S_XACC:
            begin
                cmd.op     = OP_ACC_X;
                state_next = S_YLO;
            end
            S_YLO:
            begin
                cmd.op     = OP_MUL_YLO;
                state_next = S_YHI;
            end
            S_YHI:
            begin
                cmd.op     = OP_MUL_YHI;
                state_next = S_YSUM;
            end
            S_YSUM:
            begin
                cmd.op     = OP_SUM;
                state_next = S_YACC;
            end
            S_YACC:
            begin
                cmd.op     = OP_ACC_Y;
                state_next = S_W;
            end
            S_W:
            begin
                cmd.op     = OP_MUL_WDT;
                state_next = S_R;
            end
            S_R:
            begin
                cmd.op     = OP_SET_R16;
                state_next = S_H;
            end
            S_H:
            begin
                cmd.op     = OP_MUL_RINV;
                state_next = S_HD;
            end
            S_HD:
            begin
                cmd.op     = OP_HEAD;
                state_next = S_QINIT;
            end
            S_QINIT:
            begin
                cmd.op     = OP_QUAT_INIT;
                step_next  = '0;
                state_next = S_QSTEP;
            end
            S_QSTEP:
            begin
                cmd.op = OP_CSTEP;
                if (last_step)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (!(status.out_full && out_stall))
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in flight");

    a_publish_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUBLISH) |-> !(status.out_full && out_stall))
        else $error("result overwrites a stalled beat");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RSTEP || state_reg == S_QSTEP) |-> (int'(step_reg) < NSTEP))
        else $error("rotation step beyond table");
`endif

endmodule

@@ rtl/poi_dp.sv @@
module poi_dp
    import poi_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic signed [23:0]  fwd_speed,
    input  logic signed [23:0]  side_speed,
    input  logic signed [23:0]  yaw_speed,
    input  logic [19:0]         elapsed_time,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic [15:0]         heading_angle,
    output logic signed [15:0]  quat_z,
    output logic signed [15:0]  quat_w,
    output logic signed [23:0]  speed_echo,
    output logic signed [23:0]  yaw_rate_echo
);

    localparam int SH = 48 - ANGLE_BITS;

    logic signed [23:0]         v_reg;
    logic signed [23:0]         u_reg;
    logic signed [23:0]         w_reg;
    logic [19:0]                dt_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [CORDIC_W-1:0] rx_reg;
    logic signed [CORDIC_W-1:0] ry_reg;
    logic signed [CORDIC_W-1:0] cx_reg;
    logic signed [CORDIC_W-1:0] cy_reg;
    logic signed [ZW-1:0]       cz_reg;
    logic [41:0]                lo_reg;
    logic signed [63:0]         full_reg;
    logic signed [31:0]         px_reg;
    logic signed [31:0]         py_reg;
    logic [ANGLE_BITS-1:0]      head_reg;
    logic signed [28:0]         r16_reg;
    logic                       out_valid_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic                       mul_en;
    logic [31:0]                h32;
    logic [31:0]                ang;
    logic [31:0]                ang_f;
    logic                       fold;
    logic signed [CORDIC_W-1:0] x0;
    logic signed [CORDIC_W-1:0] y0;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [ZW-1:0]       at;
    logic signed [33:0]         acc_base;
    logic signed [33:0]         acc_sum;
    logic signed [31:0]         acc_sat;
    logic signed [27:0]         qs_r;
    logic signed [27:0]         qc_r;
    logic [ANGLE_BITS-1:0]      dbits;

    assign h32 = {head_reg, {(32 - ANGLE_BITS){1'b0}}};

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (cmd.op) inside
            OP_MUL_VK:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = MUL_B_W'(INVK_Q30);
            end
            OP_MUL_UK:
            begin
                mul_a = MUL_A_W'(u_reg);
                mul_b = MUL_B_W'(INVK_Q30);
            end
            OP_MUL_XLO:
            begin
                mul_a = {10'b0, cx_reg[21:0]};
                mul_b = {11'b0, dt_reg};
            end
            OP_MUL_XHI, OP_MUL_YHI:
            begin
                mul_a = MUL_A_W'((cmd.op == OP_MUL_XHI) ? $signed(cx_reg[43:22])
                                                         : $signed(cy_reg[43:22]));
                mul_b = {11'b0, dt_reg};
            end
            OP_MUL_YLO:
            begin
                mul_a = {10'b0, cy_reg[21:0]};
                mul_b = {11'b0, dt_reg};
            end
            OP_MUL_WDT:
            begin
                mul_a = MUL_A_W'(w_reg);
                mul_b = {11'b0, dt_reg};
            end
            OP_MUL_RINV:
            begin
                mul_a = MUL_A_W'(r16_reg);
                mul_b = MUL_B_W'(INV_TWO_PI_Q32);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.op == OP_QUAT_INIT)
        begin
            x0  = CORDIC_W'({INVK_Q30, 2'b00});
            y0  = '0;
            ang = {1'b0, h32[31:1]};
        end
        else
        begin
            x0  = rx_reg;
            y0  = ry_reg;
            ang = h32;
        end
        fold  = ang[31] ^ ang[30];
        ang_f = {ang[31] ^ fold, ang[30:0]};
    end

    assign dx = cy_reg >>> cmd.step;
    assign dy = cx_reg >>> cmd.step;
    assign at = ZW'(atan_val(cmd.step));

    assign acc_base = (cmd.op == OP_ACC_X) ? 34'(px_reg) : 34'(py_reg);
    assign acc_sum  = acc_base + 34'($signed(full_reg[63:32])) + 34'(full_reg[31]);

    always_comb
    begin
        if (acc_sum[33:31] == 3'b000 || acc_sum[33:31] == 3'b111)
        begin
            acc_sat = acc_sum[31:0];
        end
        else if (acc_sum[33])
        begin
            acc_sat = 32'sh8000_0000;
        end
        else
        begin
            acc_sat = 32'sh7FFF_FFFF;
        end
    end

    assign dbits = prod_reg[SH+ANGLE_BITS-1:SH] + ANGLE_BITS'(prod_reg[SH-1]);
    assign qs_r  = 28'($signed(cy_reg[43:17])) + 28'(cy_reg[16]);
    assign qc_r  = 28'($signed(cx_reg[43:17])) + 28'(cx_reg[16]);

    function automatic logic signed [15:0] sat16(input logic signed [27:0] x);
        logic signed [15:0] r;
        if (x > 28'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (x < -28'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = x[15:0];
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        unique case (cmd.op) inside
            OP_LOAD:
            begin
                v_reg  <= fwd_speed;
                u_reg  <= side_speed;
                w_reg  <= yaw_speed;
                dt_reg <= elapsed_time;
            end
            OP_MUL_UK:
            begin
                rx_reg <= prod_reg[57:14];
            end
            OP_SET_RY:
            begin
                ry_reg <= prod_reg[57:14];
            end
            OP_ROT_INIT, OP_QUAT_INIT:
            begin
                cx_reg <= fold ? -x0 : x0;
                cy_reg <= fold ? -y0 : y0;
                cz_reg <= ZW'($signed(ang_f));
            end
            OP_CSTEP:
            begin
                if (!cz_reg[ZW-1])
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + at;
                end
            end
            OP_MUL_XHI, OP_MUL_YHI:
            begin
                lo_reg <= prod_reg[41:0];
            end
            OP_SUM:
            begin
                full_reg <= (64'(prod_reg) <<< 22) + 64'(lo_reg);
            end
            OP_SET_R16:
            begin
                r16_reg <= prod_reg[44:16] + 29'(prod_reg[15]);
            end
            OP_PUBLISH:
            begin
                pos_x         <= px_reg;
                pos_y         <= py_reg;
                heading_angle <= h32[31:16];
                quat_z        <= sat16(qs_r);
                quat_w        <= sat16(qc_r);
                speed_echo    <= v_reg;
                yaw_rate_echo <= w_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg        <= '0;
            py_reg        <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_ACC_X)
            begin
                px_reg <= acc_sat;
            end
            if (cmd.op == OP_ACC_Y)
            begin
                py_reg <= acc_sat;
            end
            if (cmd.op == OP_HEAD)
            begin
                head_reg <= head_reg + dbits;
            end
            if (cmd.op == OP_PUBLISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_full = out_valid_reg;

`ifndef SYNTHESIS
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUBLISH) |=> out_valid)
        else $error("published beat not presented");

    a_pos_only_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != OP_ACC_X) |=> $stable(px_reg))
        else $error("x position moved outside accumulate");

    a_head_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != OP_HEAD) |=> $stable(head_reg))
        else $error("heading moved outside update");
`endif

endmodule

@@ rtl/planar_odometry_integrator.sv @@
// channel | handshake          | beat contents
// in      | in_valid/in_stall  | fwd_speed, side_speed, yaw_speed, elapsed_time
// out     | out_valid/out_stall| pos_x, pos_y, heading_angle, quat_z, quat_w, speed_echo,
//         |                    | yaw_rate_echo
// Each item is worked by the shared iterative rotator, which runs twice per item,
// and the single shared multiplier; inputs stall until the item is published.
// Reset clears position and heading to zero; the block is ready right after reset.
// A stalled result is held in the output register while the next item is worked;
// only the final publish waits for it to drain.
module planar_odometry_integrator
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [23:0]  fwd_speed,
    input  logic signed [23:0]  side_speed,
    input  logic signed [23:0]  yaw_speed,
    input  logic [19:0]         elapsed_time,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic [15:0]         heading_angle,
    output logic signed [15:0]  quat_z,
    output logic signed [15:0]  quat_w,
    output logic signed [23:0]  speed_echo,
    output logic signed [23:0]  yaw_rate_echo
);

    cmd_t    cmd;
    status_t status;

    poi_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    poi_dp #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .fwd_speed     (fwd_speed),
        .side_speed    (side_speed),
        .yaw_speed     (yaw_speed),
        .elapsed_time  (elapsed_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading_angle (heading_angle),
        .quat_z        (quat_z),
        .quat_w        (quat_w),
        .speed_echo    (speed_echo),
        .yaw_rate_echo (yaw_rate_echo)
    );

endmodule
